/* design/mcg_pkg.sv */
// Shared types and constants of the midpoint circle generator.
// No dependencies; imported by the front, queue, back, top level and checker.
`default_nettype none

package mcg_pkg;

  // Item operation codes
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  // Order in which the eight mirrored points of one step leave the block
  typedef enum logic [2:0] {
    OCT_XY   = 3'd0,
    OCT_YX   = 3'd1,
    OCT_YNX  = 3'd2,
    OCT_XNY  = 3'd3,
    OCT_NXNY = 3'd4,
    OCT_NYNX = 3'd5,
    OCT_NYX  = 3'd6,
    OCT_NXY  = 3'd7
  } oct_e;

  // Decision increments for a straight and a diagonal move
  localparam int DEC_ADD_STEP = 3;
  localparam int DEC_ADD_DIAG = 5;

  // Entries of the step queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

/* design/mcg_front.sv */
// Front part: accepts items, holds the octant state and runs one midpoint step.
// Depends on mcg_pkg; pushes one step job per emitting item into the queue.
`default_nettype none

module mcg_front #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_i,
  output logic                          push_valid_o,
  input  logic                          push_stall_i,
  output logic        [COORD_BITS-1:0]  job_origin_x_o,
  output logic        [COORD_BITS-1:0]  job_origin_y_o,
  output logic        [RADIUS_BITS-1:0] job_x_o,
  output logic        [RADIUS_BITS-1:0] job_y_o,
  output logic                          job_final_o
);
  import mcg_pkg::*;

  localparam int DEC_W = RADIUS_BITS + 3;

  logic [RADIUS_BITS-1:0] offset_x_q, offset_x_d;
  logic [RADIUS_BITS-1:0] offset_y_q, offset_y_d;
  logic [DEC_W-1:0]       decision_q, decision_d;
  logic [COORD_BITS-1:0]  origin_x_q, origin_x_d;
  logic [COORD_BITS-1:0]  origin_y_q, origin_y_d;
  logic                   running_q, running_d;

  logic             is_start;
  logic             fire;
  logic [DEC_W-1:0] two_x;
  logic [DEC_W-1:0] two_y;

  assign is_start     = (op_e'(opcode_i) == OP_START);
  assign push_valid_o = in_valid_i && (is_start || running_q);
  assign in_stall_o   = push_stall_i;
  assign fire         = push_valid_o && !push_stall_i;

  assign two_x = {2'b00, offset_x_q, 1'b0};
  assign two_y = {2'b00, offset_y_q, 1'b0};

  always_comb begin
    if (is_start) begin
      origin_x_d = center_x_i;
      origin_y_d = center_y_i;
      offset_x_d = '0;
      offset_y_d = radius_i;
      decision_d = DEC_W'(1) - {3'b000, radius_i};
    end else begin
      origin_x_d = origin_x_q;
      origin_y_d = origin_y_q;
      offset_x_d = offset_x_q + RADIUS_BITS'(1);
      if (decision_q[DEC_W-1]) begin
        // straight move: keep y
        offset_y_d = offset_y_q;
        decision_d = decision_q + two_x + DEC_W'(DEC_ADD_STEP);
      end else begin
        // diagonal move: drop y by one
        offset_y_d = offset_y_q - RADIUS_BITS'(1);
        decision_d = decision_q + two_x - two_y + DEC_W'(DEC_ADD_DIAG);
      end
    end
    running_d = (offset_y_d > offset_x_d);
  end

  assign job_origin_x_o = origin_x_d;
  assign job_origin_y_o = origin_y_d;
  assign job_x_o        = offset_x_d;
  assign job_y_o        = offset_y_d;
  assign job_final_o    = !running_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
      decision_q <= '0;
      origin_x_q <= '0;
      origin_y_q <= '0;
      running_q  <= 1'b0;
    end else if (fire) begin
      offset_x_q <= offset_x_d;
      offset_y_q <= offset_y_d;
      decision_q <= decision_d;
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
      running_q  <= running_d;
    end
  end

endmodule

`default_nettype wire

/* design/mcg_queue.sv */
// Short step queue between front and back, held in flip-flops.
// Depends on mcg_pkg for its depth.
`default_nettype none

module mcg_queue #(
  parameter int WIDTH = 45
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_stall_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import mcg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_stall_o = (count_q == CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* design/mcg_back.sv */
// Back part: emits eight mirrored points per step job, one a cycle unless held.
// Depends on mcg_pkg; drives the registered result channel.
`default_nettype none

module mcg_back #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_stall_o,
  input  logic [COORD_BITS-1:0]        job_origin_x_i,
  input  logic [COORD_BITS-1:0]        job_origin_y_i,
  input  logic [RADIUS_BITS-1:0]       job_x_i,
  input  logic [RADIUS_BITS-1:0]       job_y_i,
  input  logic                         job_final_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS:0]   point_x_o,
  output logic signed [COORD_BITS:0]   point_y_o,
  output logic                         last_point_o
);
  import mcg_pkg::*;

  localparam int OUT_W = COORD_BITS + 1;
  localparam int SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  logic [COORD_BITS-1:0]  origin_x_q, origin_y_q;
  logic [RADIUS_BITS-1:0] x_q, y_q;
  logic                   final_q;
  logic                   have_job_q;
  oct_e                   idx_q;

  logic                   out_valid_q;
  logic [OUT_W-1:0]       point_x_q, point_y_q;
  logic                   last_q;

  logic             out_free, advance, at_end, pop;
  logic [SUM_W-1:0] ex, ey, ox, oy, dx, dy, sum_x, sum_y;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = have_job_q && out_free;
  assign at_end      = (idx_q == OCT_NXY);
  assign pop_stall_o = have_job_q && !(advance && at_end);
  assign pop         = pop_valid_i && !pop_stall_o;

  assign ex = {{(SUM_W - RADIUS_BITS){1'b0}}, x_q};
  assign ey = {{(SUM_W - RADIUS_BITS){1'b0}}, y_q};
  assign ox = {{(SUM_W - COORD_BITS){origin_x_q[COORD_BITS-1]}}, origin_x_q};
  assign oy = {{(SUM_W - COORD_BITS){origin_y_q[COORD_BITS-1]}}, origin_y_q};

  always_comb begin
    unique case (idx_q)
      OCT_XY:   begin dx = ex;  dy = ey;  end
      OCT_YX:   begin dx = ey;  dy = ex;  end
      OCT_YNX:  begin dx = ey;  dy = -ex; end
      OCT_XNY:  begin dx = ex;  dy = -ey; end
      OCT_NXNY: begin dx = -ex; dy = -ey; end
      OCT_NYNX: begin dx = -ey; dy = -ex; end
      OCT_NYX:  begin dx = -ey; dy = ex;  end
      OCT_NXY:  begin dx = -ex; dy = ey;  end
      default:  begin dx = ex;  dy = ey;  end
    endcase
  end

  assign sum_x = ox + dx;
  assign sum_y = oy + dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_job_q  <= 1'b0;
      idx_q       <= OCT_XY;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        have_job_q <= 1'b1;
        idx_q      <= OCT_XY;
      end else if (advance) begin
        idx_q <= oct_e'(idx_q + 3'd1);
        if (at_end) begin
          have_job_q <= 1'b0;
        end
      end
      if (out_free) begin
        out_valid_q <= have_job_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      origin_x_q <= job_origin_x_i;
      origin_y_q <= job_origin_y_i;
      x_q        <= job_x_i;
      y_q        <= job_y_i;
      final_q    <= job_final_i;
    end
    if (advance) begin
      point_x_q <= sum_x[OUT_W-1:0];
      point_y_q <= sum_y[OUT_W-1:0];
      last_q    <= final_q && at_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign point_x_o    = point_x_q;
  assign point_y_o    = point_y_q;
  assign last_point_o = last_q;

endmodule

`default_nettype wire

/* design/midpoint_circle_generator_core.sv */
// Top level of the midpoint circle generator: front, step queue and back.
// Depends on mcg_pkg, mcg_front, mcg_queue and mcg_back.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o | opcode, center_x, center_y, radius
//   out     | output    | out_valid_o / out_stall_i | point_x, point_y, last_point
//
// Each start or advance beat that emits points yields eight output beats, one per
// cycle while the output is not stalled, so the sustained rate of items is set by
// the single output port. With queue and back idle, the first point passes through a
// queue entry, the back's job registers and its output register before it is shown.
// An advance beat with no step left is taken and emits nothing.
// Reset clears the octant state, queue pointers and output valid at once.
// Output stall backs up into the two-entry step queue, then into in_stall_o.
`default_nettype none

module midpoint_circle_generator_core #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS:0]    point_x_o,
  output logic signed [COORD_BITS:0]    point_y_o,
  output logic                          last_point_o
);
  import mcg_pkg::*;

  // One queued step: origin, octant point and the final-step flag
  localparam int JOB_W = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

  logic                   push_valid, push_stall;
  logic                   pop_valid, pop_stall;
  logic [COORD_BITS-1:0]  f_origin_x, f_origin_y, b_origin_x, b_origin_y;
  logic [RADIUS_BITS-1:0] f_x, f_y, b_x, b_y;
  logic                   f_final, b_final;
  logic [JOB_W-1:0]       push_data, pop_data;

  // Classify the beat and run the midpoint step
  mcg_front #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_i       (radius_i),
    .push_valid_o   (push_valid),
    .push_stall_i   (push_stall),
    .job_origin_x_o (f_origin_x),
    .job_origin_y_o (f_origin_y),
    .job_x_o        (f_x),
    .job_y_o        (f_y),
    .job_final_o    (f_final)
  );

  assign push_data = {f_origin_x, f_origin_y, f_x, f_y, f_final};

  // Decouple step generation from point emission
  mcg_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_stall_i  (pop_stall),
    .pop_data_o   (pop_data)
  );

  assign {b_origin_x, b_origin_y, b_x, b_y, b_final} = pop_data;

  // Mirror each step into eight points
  mcg_back #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_stall_o    (pop_stall),
    .job_origin_x_i (b_origin_x),
    .job_origin_y_i (b_origin_y),
    .job_x_i        (b_x),
    .job_y_i        (b_y),
    .job_final_i    (b_final),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .last_point_o   (last_point_o)
  );

endmodule

`default_nettype wire

/* design/mcg_checker.sv */
// Port-level checks for the midpoint circle generator, bound to the top level.
// Depends on mcg_pkg and midpoint_circle_generator_core.
`default_nettype none

module mcg_checker #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic signed [COORD_BITS:0]    point_x_o,
  input  logic signed [COORD_BITS:0]    point_y_o,
  input  logic                          last_point_o
);
  import mcg_pkg::*;

  logic in_beat, out_beat;
  logic seen_start_q;
  oct_e slot_q;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // Track whether any circle was started and the point slot within a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_start_q <= 1'b0;
      slot_q       <= OCT_XY;
    end else begin
      if (in_beat && op_e'(opcode_i) == OP_START) begin
        seen_start_q <= 1'b1;
      end
      if (out_beat) begin
        slot_q <= oct_e'(slot_q + 3'd1);
      end
    end
  end

  // No point leaves before a circle was started
  a_no_point_before_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_start_q)
    else $error("output beat before any start");

  // The final point is always the eighth point of its step
  a_last_on_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && last_point_o) |-> (slot_q == OCT_NXY))
    else $error("last point not on eighth slot of a step");

  // A stalled result holds valid
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped under stall");

  // A stalled result holds its payload
  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(point_x_o) && $stable(point_y_o) && $stable(last_point_o)))
    else $error("output payload changed under stall");

endmodule

bind midpoint_circle_generator_core mcg_checker #(
  .RADIUS_BITS (RADIUS_BITS),
  .COORD_BITS  (COORD_BITS)
) u_mcg_checker (.*);

`default_nettype wire

/* test/testbench.sv */
// Self-checking bench for midpoint_circle_generator_core: paced start and advance beats,
// a scoreboard class that predicts every mirrored point, and an in-order point checker.
// Depends on mcg_pkg and the generator RTL; nothing else.

module testbench;
  import mcg_pkg::*;

  localparam int RADIUS_BITS   = 10;
  localparam int COORD_BITS    = 12;
  localparam int RANDOM_ITEMS  = 480;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 250;
  localparam int SETTLE_CYCLES = 16;

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic        [RADIUS_BITS-1:0] radius_t;
  typedef logic signed [COORD_BITS:0]    pixel_t;
  typedef logic signed [RADIUS_BITS+2:0] dec_t;

  typedef struct packed {
    pixel_t px;
    pixel_t py;
    logic   last;
  } plot_point_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_COMB, STALL_HEAVY} stall_mode_e;

  localparam coord_t  COORD_MAX  = 2047;
  localparam coord_t  COORD_MIN  = -2048;
  localparam radius_t RADIUS_MAX = 1023;

  // Tracks the rasterizer state and holds the points still owed by the block.
  class circle_scoreboard;
    radius_t     ofs_x, ofs_y;
    dec_t        decision;
    coord_t      org_x, org_y;
    bit          running;
    plot_point_t plot_q[$];
    int          errors, points_checked, point_beats;
    int          circles_started, steps_taken, idle_advances;

    function new();
      ofs_x = '0;
      ofs_y = '0;
      decision = '0;
      org_x = '0;
      org_y = '0;
      running = 1'b0;
      errors = 0;
      points_checked = 0;
      point_beats = 0;
      circles_started = 0;
      steps_taken = 0;
      idle_advances = 0;
    endfunction

    function int pending();
      return plot_q.size();
    endfunction

    function void flag(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    // Queue the eight mirrored points of the current octant point
    function void queue_octants(bit closing);
      int x, y, dx, dy;
      plot_point_t pt;
      x = int'(ofs_x);
      y = int'(ofs_y);
      for (int k = 0; k < 8; k++) begin
        case (oct_e'(k))
          OCT_XY:   begin dx = x;  dy = y;  end
          OCT_YX:   begin dx = y;  dy = x;  end
          OCT_YNX:  begin dx = y;  dy = -x; end
          OCT_XNY:  begin dx = x;  dy = -y; end
          OCT_NXNY: begin dx = -x; dy = -y; end
          OCT_NYNX: begin dx = -y; dy = -x; end
          OCT_NYX:  begin dx = -y; dy = x;  end
          OCT_NXY:  begin dx = -x; dy = y;  end
        endcase
        pt.px = pixel_t'(int'(org_x) + dx);
        pt.py = pixel_t'(int'(org_y) + dy);
        pt.last = closing && (oct_e'(k) == OCT_NXY);
        plot_q.push_back(pt);
      end
    endfunction

    // Apply one accepted input beat; return how many points it owes
    function int note_item(op_e op, coord_t cx, coord_t cy, radius_t r);
      int xp, yp, nd;
      if (op == OP_START) begin
        org_x = cx;
        org_y = cy;
        ofs_x = '0;
        ofs_y = r;
        decision = dec_t'(1 - int'(r));
        running = ofs_y > ofs_x;
        circles_started++;
        point_beats++;
        queue_octants(!running);
        return 8;
      end
      if (!running) begin
        idle_advances++;
        return 0;
      end
      xp = int'(ofs_x);
      yp = int'(ofs_y);
      if (decision < 0) begin
        nd = int'(decision) + 2 * xp + DEC_ADD_STEP;
      end else begin
        ofs_y = ofs_y - 1'b1;
        nd = int'(decision) + 2 * (xp - yp) + DEC_ADD_DIAG;
      end
      ofs_x = ofs_x + 1'b1;
      decision = dec_t'(nd);
      running = ofs_y > ofs_x;
      steps_taken++;
      point_beats++;
      queue_octants(!running);
      return 8;
    endfunction

    // Compare one accepted output beat against the oldest owed point
    function void check_point(pixel_t px, pixel_t py, logic lp);
      plot_point_t want;
      if (plot_q.size() == 0) begin
        flag($sformatf("unexpected point (%0d,%0d) last=%0b", px, py, lp));
        return;
      end
      want = plot_q.pop_front();
      points_checked++;
      if (px !== want.px)
        flag($sformatf("point_x expected %0d actual %0d", want.px, px));
      if (py !== want.py)
        flag($sformatf("point_y expected %0d actual %0d", want.py, py));
      if (lp !== want.last)
        flag($sformatf("last_point expected %0b actual %0b", want.last, lp));
    endfunction
  endclass

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    opcode_i    = OP_ADVANCE;
  coord_t  center_x_i  = '0;
  coord_t  center_y_i  = '0;
  radius_t radius_i    = '0;
  logic    out_stall_i = 1'b0;
  logic    in_stall_o;
  logic    out_valid_o;
  pixel_t  point_x_o;
  pixel_t  point_y_o;
  logic    last_point_o;

  circle_scoreboard sb;

  // Sender pacing and the long receiver hold-off request
  int   burst_left = 0;
  logic hold_req   = 1'b0;
  int   cycles     = 0;

  midpoint_circle_generator_core #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .last_point_o(last_point_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: end the run once the cycle limit is reached
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d points outstanding", $time, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sample both channels at the rising edge; inputs were settled at the falling edge,
  // so an input beat is always noted before any point it can produce.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        void'(sb.note_item(op_e'(opcode_i), center_x_i, center_y_i, radius_i));
      if (out_valid_o && !out_stall_i)
        sb.check_point(point_x_o, point_y_o, last_point_o);
    end
  end

  // Receiver stall: segments of no stall, coin flips, a fixed comb and heavy stall,
  // overridden by a long hold-off whenever the stimulus raises hold_req.
  int          hold_left  = 0;
  int          stall_seg  = 0;
  stall_mode_e stall_mode = STALL_NONE;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_seg == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_seg = $urandom_range(16, 120);
      end
      stall_seg--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_COIN:  out_stall_i <= ($urandom_range(0, 1) == 0);
        STALL_COMB:  out_stall_i <= (stall_seg % 3 == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic radius_t rand_radius();
    return radius_t'($urandom);
  endfunction

  // Mostly small circles so most of them finish; a few medium and full-range ones
  function automatic radius_t pick_radius();
    int sel;
    sel = $urandom_range(0, 39);
    if (sel == 0) return rand_radius();
    if (sel < 5) return radius_t'($urandom_range(25, 160));
    return radius_t'($urandom_range(0, 24));
  endfunction

  // Present one beat at the falling edge and hold it until the block takes it
  task automatic drive_beat(op_e op, coord_t cx, coord_t cy, radius_t r);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Send in bursts; between bursts drop valid for a random gap (sometimes none)
  task automatic offer(op_e op, coord_t cx, coord_t cy, radius_t r);
    if (burst_left == 0) begin
      idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    drive_beat(op, cx, cy, r);
  endtask

  // Pause the sender until every owed point has left, then let the block settle
  task automatic drain(int settle);
    do idle_cycles(1); while (sb.pending() != 0);
    idle_cycles(settle);
  endtask

  // One circle: start plus enough advances to finish it (large ones are cut short), sometimes
  // overshooting into advances on a finished circle; when abandoned, cut the advances short
  // so the next start lands mid-circle.
  task automatic random_circle(bit abandon);
    radius_t r;
    int      steps;
    r = pick_radius();
    steps = (int'(r) * 181) / 256 + 1;
    if (steps > 48) steps = $urandom_range(4, 48);
    else if ($urandom_range(0, 3) == 0) steps += $urandom_range(1, 2);
    if (abandon) steps = $urandom_range(0, steps - 1);
    offer(OP_START, rand_coord(), rand_coord(), r);
    repeat (steps) offer(OP_ADVANCE, rand_coord(), rand_coord(), rand_radius());
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      offer(op_e'($urandom_range(0, 1)), rand_coord(), rand_coord(), pick_radius());
  endtask

  initial begin
    int mark;
    int pick;
    int drains;
    drains = 0;
    sb = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: advance on an idle block, zero radius, advance after completion
    offer(OP_ADVANCE, '0, '0, '0);
    offer(OP_START, COORD_MIN, COORD_MAX, '0);
    offer(OP_ADVANCE, COORD_MAX, COORD_MIN, RADIUS_MAX);
    // Largest radius at the extreme corner; advance fields carry junk that must be ignored
    offer(OP_START, COORD_MAX, COORD_MIN, RADIUS_MAX);
    offer(OP_ADVANCE, -1, '0, RADIUS_MAX);
    offer(OP_ADVANCE, COORD_MIN, COORD_MAX, '0);
    offer(OP_ADVANCE, '0, -1, 10'h2AA);
    // Restart mid-circle at another corner
    offer(OP_START, COORD_MIN, COORD_MIN, RADIUS_MAX);
    offer(OP_ADVANCE, '0, '0, '0);
    offer(OP_ADVANCE, '0, '0, '0);
    // Tiny circles run to completion, one extra advance each
    offer(OP_START, '0, '0, 10'd1);
    repeat (2) offer(OP_ADVANCE, '0, '0, '0);
    offer(OP_START, COORD_MAX, COORD_MAX, 10'd2);
    repeat (3) offer(OP_ADVANCE, '0, '0, '0);
    offer(OP_START, -1, -1, 10'd3);
    repeat (3) offer(OP_ADVANCE, '0, '0, '0);
    drain(SETTLE_CYCLES);
    drains++;

    // Back-pressure: hold the receiver off while beats keep coming, so the step
    // queue fills and the block stalls its input
    hold_req <= 1'b1;
    drive_beat(OP_START, rand_coord(), rand_coord(), 10'd200);
    repeat (12) drive_beat(OP_ADVANCE, rand_coord(), rand_coord(), rand_radius());
    drain(SETTLE_CYCLES);
    drains++;

    // Random: mostly well-formed circles, some abandoned ones and some noise
    mark = sb.point_beats;
    while (sb.point_beats < mark + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        random_circle(1'b0);
      end else if (pick < 16) begin
        random_circle(1'b1);
      end else if (pick < 19) begin
        noise_burst();
      end else begin
        drain(SETTLE_CYCLES);
        drains++;
      end
    end
    drain(SETTLE_CYCLES);

    $display("Run covered %0d circles, %0d octant steps and %0d ignored advances;",
             sb.circles_started, sb.steps_taken, sb.idle_advances);
    $display("%0d points compared, %0d sender drains, %0d mismatches.",
             sb.points_checked, drains, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/mcg_pkg.sv
design/mcg_front.sv
design/mcg_queue.sv
design/mcg_back.sv
design/midpoint_circle_generator_core.sv
design/mcg_checker.sv
test/testbench.sv
